### sv/lcgx_pkg.sv
// shared types and constants of the lcg keystream xor cipher
`default_nettype none
package lcgx_pkg;

   localparam int unsigned WORD_W = 32;
   localparam int unsigned CNT_W  = 6;

   // configuration register indexes
   localparam logic [1:0] REG_SEED = 2'd0;
   localparam logic [1:0] REG_MULT = 2'd1;
   localparam logic [1:0] REG_INCR = 2'd2;
   localparam logic [1:0] REG_MOD  = 2'd3;

   localparam logic [31:0] RESET_SEED = 32'd0;
   localparam logic [31:0] RESET_MULT = 32'd20011;
   localparam logic [31:0] RESET_INCR = 32'd10007;
   localparam logic [31:0] RESET_MOD  = 32'd100003;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_MUL,
      DIV_RUN,
      DIV_DONE
   } div_state_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_STEP,
      SEQ_WAIT,
      SEQ_OUT
   } seq_state_type;

   // one generator step request
   typedef struct packed {
      logic [31:0] x;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] m;
   } step_req_type;

   // one generator step result
   typedef struct packed {
      logic [31:0] value;
      logic        err;
   } step_rsp_type;

endpackage
`default_nettype wire

### sv/lcgx_step.sv
// one generator step: x*a+b over four 8-bit partial products, then a
// bit-serial signed remainder
`default_nettype none
module lcgx_step
   import lcgx_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire step_req_type req,
   output logic              done,
   output step_rsp_type      rsp
);

   div_state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [31:0] acc_ff, acc_in;       // product accumulator, then dividend shifter
   logic [31:0] a_ff, a_in;
   logic [31:0] x_ff, x_in;
   logic [31:0] b_ff, b_in;
   logic [31:0] dvs_ff, dvs_in;       // divisor magnitude
   logic [31:0] rem_ff, rem_in;
   logic        neg_ff, neg_in;
   logic        err_ff, err_in;
   logic        m_sign_ff, m_sign_in;

   logic [31:0] part;
   logic [32:0] trial;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         DIV_IDLE: if (start) state_in = DIV_MUL;
         DIV_MUL:  if (cnt_ff == CNT_W'(3)) state_in = DIV_RUN;
         DIV_RUN:  if (cnt_ff == CNT_W'(31)) state_in = DIV_DONE;
         DIV_DONE: state_in = DIV_IDLE;
         default:  state_in = DIV_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      cnt_in = cnt_ff;
      acc_in = acc_ff;
      a_in = a_ff;
      x_in = x_ff;
      b_in = b_ff;
      dvs_in = dvs_ff;
      rem_in = rem_ff;
      neg_in = neg_ff;
      err_in = err_ff;
      m_sign_in = m_sign_ff;
      part = a_ff * {24'd0, x_ff[7:0]};
      trial = {rem_ff, acc_ff[31]} - {1'b0, dvs_ff};
      case (state_ff)
         DIV_IDLE: begin
            if (start) begin
               cnt_in = '0;
               acc_in = '0;
               a_in = req.a;
               x_in = req.x;
               b_in = req.b;
               dvs_in = req.m[31] ? (~req.m + 32'd1) : req.m;
               m_sign_in = req.m[31];
               err_in = (req.m == 32'd0);
            end
         end
         DIV_MUL: begin
            // one byte of x per cycle
            acc_in = acc_ff + part;
            a_in = {a_ff[23:0], 8'd0};
            x_in = {8'd0, x_ff[31:8]};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(3)) begin
               cnt_in = '0;
            end
         end
         default: ;
      endcase
      if (state_ff == DIV_MUL && cnt_ff == CNT_W'(3)) begin
         // acc_in holds x*a; add b and split sign off
         logic [31:0] v;
         v = acc_ff + part + b_ff;
         neg_in = v[31];
         acc_in = v[31] ? (~v + 32'd1) : v;
         rem_in = '0;
         if (v == 32'h8000_0000 && m_sign_ff && dvs_ff == 32'd1) err_in = 1'b1;
      end
      if (state_ff == DIV_RUN) begin
         // restoring remainder, one dividend bit a cycle
         if (!trial[32]) rem_in = trial[31:0];
         else rem_in = {rem_ff[30:0], acc_ff[31]};
         acc_in = {acc_ff[30:0], 1'b0};
         cnt_in = cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
      end
      acc_ff <= acc_in;
      a_ff <= a_in;
      x_ff <= x_in;
      b_ff <= b_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
      err_ff <= err_in;
      m_sign_ff <= m_sign_in;
   end

   // remainder takes dividend sign
   always_comb begin
      done = (state_ff == DIV_DONE);
      rsp.err = err_ff;
      if (err_ff) rsp.value = '0;
      else if (neg_ff) rsp.value = ~rem_ff + 32'd1;
      else rsp.value = rem_ff;
   end

endmodule
`default_nettype wire

### sv/lcg_multiround_xor_stream_cipher_unit.sv
// top level of the multi-round lcg keystream xor cipher
//  channel | dir | handshake                  | payload
//  req     | in  | req_tvalid / req_tready    | tdata = data_byte, tuser = first
//  rsp     | out | rsp_tvalid / rsp_tready    | tdata = out_byte, tuser = error
//  csr     | in  | psel / penable, pready = 1 | seed, multiplier, increment, modulus
// each generator step runs in the shared step unit: a start, the multiply over
// the bytes of x, the remainder over the dividend bits, a result; a byte is
// accepted, then takes ROUNDS steps and an output that may stall, a first
// byte 4*(ROUNDS-1) more steps for the round setup.
// reset is synchronous and clears control state and round tables.
// an item is taken only once the previous result has left rsp.
`default_nettype none
module lcg_multiround_xor_stream_cipher_unit
   import lcgx_pkg::*;
#(
   parameter int ROUNDS = 5
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // data_byte
   input  wire logic        req_tuser,   // first
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // out_byte
   output logic             rsp_tuser,   // error
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int RW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

   logic [31:0] cfg_ff [4];
   logic [31:0] seed_ff [ROUNDS];
   logic [31:0] mult_ff [ROUNDS];
   logic [31:0] incr_ff [ROUNDS];
   logic [31:0] mod_ff  [ROUNDS];
   logic [31:0] gen_ff  [ROUNDS];

   seq_state_type state_ff, state_in;
   logic [RW-1:0] rnd_ff, rnd_in;
   logic [1:0]    k_ff, k_in;
   logic          setup_ff, setup_in;    // deriving later rounds
   logic [31:0]   x_ff, x_in;
   logic [7:0]    data_ff, data_in;
   logic [7:0]    key_ff, key_in;
   logic          err_ff, err_in;

   logic         st_start, st_done;
   step_req_type st_req;
   step_rsp_type st_rsp;

   logic cfg_wr;
   assign cfg_wr = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = cfg_ff[csr_paddr[3:2]];

   lcgx_step u_step (
      .clock (clock),
      .reset (reset),
      .start (st_start),
      .req   (st_req),
      .done  (st_done),
      .rsp   (st_rsp)
   );

   // step operands
   always_comb begin
      st_req.x = setup_ff ? x_ff : gen_ff[rnd_ff];
      st_req.a = mult_ff[rnd_ff];
      st_req.b = incr_ff[rnd_ff];
      st_req.m = mod_ff[rnd_ff];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SEQ_IDLE: if (req_tvalid) state_in = SEQ_STEP;
         SEQ_STEP: state_in = SEQ_WAIT;
         SEQ_WAIT: begin
            if (st_done) begin
               if (!setup_ff && rnd_ff == RW'(ROUNDS - 1)) state_in = SEQ_OUT;
               else state_in = SEQ_STEP;
            end
         end
         SEQ_OUT: if (rsp_tready) state_in = SEQ_IDLE;
         default: state_in = SEQ_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready = (state_ff == SEQ_IDLE);
      st_start = (state_ff == SEQ_STEP);
      rsp_tvalid = (state_ff == SEQ_OUT);
      rsp_tdata = data_ff ^ key_ff;
      rsp_tuser = err_ff;
   end

   // sequencing
   always_comb begin
      rnd_in = rnd_ff;
      k_in = k_ff;
      setup_in = setup_ff;
      x_in = x_ff;
      data_in = data_ff;
      key_in = key_ff;
      err_in = err_ff;
      if (state_ff == SEQ_IDLE && req_tvalid) begin
         data_in = req_tdata;
         key_in = '0;
         err_in = 1'b0;
         rnd_in = '0;
         k_in = '0;
         setup_in = req_tuser && (ROUNDS > 1);
         x_in = cfg_ff[REG_SEED];
      end
      if (state_ff == SEQ_WAIT && st_done) begin
         if (setup_ff) begin
            x_in = st_rsp.value;
            k_in = k_ff + 2'd1;
            if (k_ff == 2'd3) begin
               // next round starts from its seed, the first output of this one
               rnd_in = rnd_ff + RW'(1);
               x_in = seed_ff[rnd_ff + RW'(1)];
               if (rnd_ff == RW'(ROUNDS - 2)) begin
                  setup_in = 1'b0;
                  rnd_in = '0;
               end
            end
         end else begin
            key_in = key_ff ^ st_rsp.value[7:0];
            err_in = err_ff | st_rsp.err;
            rnd_in = rnd_ff + RW'(1);
         end
      end
   end

   // state, configuration registers, round tables and sequencing registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         setup_ff <= 1'b0;
         cfg_ff[REG_SEED] <= RESET_SEED;
         cfg_ff[REG_MULT] <= RESET_MULT;
         cfg_ff[REG_INCR] <= RESET_INCR;
         cfg_ff[REG_MOD]  <= RESET_MOD;
         for (int i = 0; i < ROUNDS; i++) begin
            seed_ff[i] <= '0;
            mult_ff[i] <= '0;
            incr_ff[i] <= '0;
            mod_ff[i]  <= '0;
            gen_ff[i]  <= '0;
         end
      end else begin
         state_ff <= state_in;
         setup_ff <= setup_in;
         if (cfg_wr) cfg_ff[csr_paddr[3:2]] <= csr_pwdata;
         if (state_ff == SEQ_IDLE && req_tvalid && req_tuser) begin
            seed_ff[0] <= cfg_ff[REG_SEED];
            mult_ff[0] <= cfg_ff[REG_MULT];
            incr_ff[0] <= cfg_ff[REG_INCR];
            mod_ff[0]  <= cfg_ff[REG_MOD];
            gen_ff[0]  <= cfg_ff[REG_SEED];
         end
         if (state_ff == SEQ_WAIT && st_done) begin
            if (setup_ff) begin
               case (k_ff)
                  2'd0: begin
                     seed_ff[rnd_ff + RW'(1)] <= st_rsp.value;
                     gen_ff[rnd_ff + RW'(1)]  <= st_rsp.value;
                  end
                  2'd1: mult_ff[rnd_ff + RW'(1)] <= st_rsp.value;
                  2'd2: incr_ff[rnd_ff + RW'(1)] <= st_rsp.value;
                  default: mod_ff[rnd_ff + RW'(1)] <= st_rsp.value;
               endcase
            end else begin
               gen_ff[rnd_ff] <= st_rsp.value;
            end
         end
      end
      rnd_ff <= rnd_in;
      k_ff <= k_in;
      x_ff <= x_in;
      data_ff <= data_in;
      key_ff <= key_in;
      err_ff <= err_in;
   end

   // checks
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      st_start |=> !st_done) else $error("step done right after start");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped while stalled");
   a_no_setup_out: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !setup_ff) else $error("result during round setup");

endmodule
`default_nettype wire

### tb/sv/tb.sv
// testbench of the multi-round lcg keystream xor cipher
`timescale 1ns / 1ps
`default_nettype none

class cipher_scoreboard;
   // predictor state
   logic [31:0] cfg_seed, cfg_mult, cfg_incr, cfg_mod;
   logic [31:0] rnd_seed[5], rnd_mult[5], rnd_incr[5], rnd_mod[5], gen[5];
   logic [8:0]  expected_q[$];   // {error, out_byte}
   int          mismatches;

   function new();
      cfg_seed = lcgx_pkg::RESET_SEED;
      cfg_mult = lcgx_pkg::RESET_MULT;
      cfg_incr = lcgx_pkg::RESET_INCR;
      cfg_mod  = lcgx_pkg::RESET_MOD;
      for (int r = 0; r < 5; r++) begin
         rnd_seed[r] = 0; rnd_mult[r] = 0; rnd_incr[r] = 0; rnd_mod[r] = 0; gen[r] = 0;
      end
      mismatches = 0;
   endfunction

   function void write_reg(logic [1:0] idx, logic [31:0] v);
      case (idx)
         lcgx_pkg::REG_SEED: cfg_seed = v;
         lcgx_pkg::REG_MULT: cfg_mult = v;
         lcgx_pkg::REG_INCR: cfg_incr = v;
         default:            cfg_mod  = v;
      endcase
   endfunction

   // one generator step with truncating signed remainder
   function logic [31:0] gen_step(logic [31:0] x, a, b, m, inout bit err);
      logic signed [31:0] sv, sm;
      sv = x * a + b;
      sm = m;
      if (sm == 0 || (sv == 32'sh8000_0000 && sm == -1)) begin
         err = 1;
         return 0;
      end
      return sv % sm;
   endfunction

   function void note_byte(logic [7:0] data, bit first);
      bit err, dummy;
      logic [7:0] key;
      logic [31:0] x, o[4];
      err = 0; dummy = 0; key = 0;
      if (first) begin
         rnd_seed[0] = cfg_seed; rnd_mult[0] = cfg_mult;
         rnd_incr[0] = cfg_incr; rnd_mod[0] = cfg_mod;
         for (int r = 0; r < 4; r++) begin
            x = rnd_seed[r];
            for (int k = 0; k < 4; k++) begin
               x = gen_step(x, rnd_mult[r], rnd_incr[r], rnd_mod[r], dummy);
               o[k] = x;
            end
            rnd_seed[r+1] = o[0]; rnd_mult[r+1] = o[1];
            rnd_incr[r+1] = o[2]; rnd_mod[r+1] = o[3];
         end
         for (int r = 0; r < 5; r++) gen[r] = rnd_seed[r];
      end
      for (int r = 0; r < 5; r++) begin
         gen[r] = gen_step(gen[r], rnd_mult[r], rnd_incr[r], rnd_mod[r], err);
         key ^= gen[r][7:0];
      end
      expected_q.push_back({err, data ^ key});
   endfunction

   function void check_result(logic [7:0] out_byte, logic error);
      logic [8:0] e;
      if (expected_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result %h err %b", out_byte, error);
         return;
      end
      e = expected_q.pop_front();
      if (e !== {error, out_byte}) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: expected byte %h err %b, got byte %h err %b",
                     e[7:0], e[8], out_byte, error);
      end
   endfunction
endclass

module tb;
   import lcgx_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0, req_tuser = 0;
   logic [7:0]  req_tdata = 0;   // data_byte
   wire         req_tready;
   wire         rsp_tvalid;
   logic        rsp_tready = 0;
   wire  [7:0]  rsp_tdata;       // out_byte
   wire         rsp_tuser;       // error
   logic        csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [3:0]  csr_paddr = 0;
   logic [31:0] csr_pwdata = 0;
   wire  [31:0] csr_prdata;
   wire         csr_pready;

   cipher_scoreboard sb = new();
   bit stall_mode = 0;

   lcg_multiround_xor_stream_cipher_unit dut (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   // receiver stall pattern, checking of results
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
      if (!stall_mode) rsp_tready <= 1;
      else rsp_tready <= ($urandom_range(0, 3) != 0);
   end

   task automatic csr_write(logic [1:0] idx, logic [31:0] v);
      csr_psel <= 1; csr_pwrite <= 1; csr_penable <= 0;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      sb.write_reg(idx, v);
   endtask

   task automatic send_byte(logic [7:0] d, bit first);
      req_tvalid <= 1; req_tdata <= d; req_tuser <= first;
      do @(posedge clock); while (!req_tready);
      sb.note_byte(d, first);
   endtask

   task automatic idle_gap();
      req_tvalid <= 0;
      repeat ($urandom_range(1, 60)) @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic random_message(int len);
      int burst;
      burst = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
         send_byte(8'($urandom_range(0, 255)), i == 0);
         if (--burst == 0) begin
            burst = $urandom_range(1, 8);
            if ($urandom_range(0, 1)) idle_gap();
         end
      end
   endtask

   function automatic logic [31:0] rand_word(int kind);
      case (kind)
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'hffff_ffff;
         3: return $urandom_range(0, 300) - 150;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int n;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // bytes before any first byte use cleared state
      send_byte(8'h00, 0); send_byte(8'hff, 0); send_byte(8'h5a, 0);
      // default registers, extremes of data
      send_byte(8'h00, 1); send_byte(8'hff, 0); send_byte(8'h80, 0);
      send_byte(8'h01, 0); send_byte(8'h7f, 0);
      // short message then restart
      send_byte(8'haa, 1); send_byte(8'h55, 0); send_byte(8'h33, 1);
      send_byte(8'hcc, 0); send_byte(8'h0f, 0); send_byte(8'hf0, 0);
      drain();
      // zero modulus
      csr_write(REG_MOD, 0);
      send_byte(8'h12, 1); send_byte(8'h34, 0); send_byte(8'h56, 0); send_byte(8'h78, 0);
      drain();
      // minimum divided by minus one
      csr_write(REG_SEED, 0); csr_write(REG_MULT, 0);
      csr_write(REG_INCR, 32'h8000_0000); csr_write(REG_MOD, 32'hffff_ffff);
      send_byte(8'h9a, 1); send_byte(8'hbc, 0); send_byte(8'hde, 0); send_byte(8'hf1, 0);
      drain();
      // extremes of all registers
      csr_write(REG_SEED, 32'h7fff_ffff); csr_write(REG_MULT, 32'h8000_0000);
      csr_write(REG_INCR, 32'h7fff_ffff); csr_write(REG_MOD, 32'h8000_0000);
      send_byte(8'h11, 1); send_byte(8'h22, 0); send_byte(8'h44, 0); send_byte(8'h88, 0);
      drain();
      stall_mode = 1;
      // random phases with varied settings
      n = 0;
      for (int ph = 0; n < 1270; ph++) begin
         if (ph % 4 == 0) begin
            csr_write(REG_SEED, rand_word($urandom_range(0, 6)));
            csr_write(REG_MULT, rand_word($urandom_range(0, 6)));
            csr_write(REG_INCR, rand_word($urandom_range(0, 6)));
            csr_write(REG_MOD, ($urandom_range(0, 3) == 0) ?
                      rand_word($urandom_range(0, 6)) : $urandom_range(3, 200000));
         end
         stall_mode = (ph % 3 != 0);
         for (int m = 0; m < 8; m++) begin
            int len;
            len = $urandom_range(4, 12);
            random_message(len);
            n += len;
         end
         if ($urandom_range(0, 9) == 0) send_byte(8'($urandom_range(0, 255)), 0);
         drain();
      end
      if (sb.mismatches == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

   initial begin
      #100ms;
      $display("TEST FAILED");
      $finish;
   end
endmodule
`default_nettype wire

### sim.f
sv/lcgx_pkg.sv
sv/lcgx_step.sv
sv/lcg_multiround_xor_stream_cipher_unit.sv
tb/sv/tb.sv
